// ----- design/ksdt_pkg.sv -----
// Shared types and constants for the k-th smallest distance tracker.
package ksdt_pkg;

   localparam int COORD_W    = 32;
   localparam int DIST_W     = 33;
   localparam int KRANK_W    = 11;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // register index, taken from paddr[2]
   localparam logic REG_K_RANK = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIST,
      ST_DECIDE,
      ST_UP_RD,
      ST_UP_CMP,
      ST_DN_RD,
      ST_DN_CMP,
      ST_RESP
   } ksdt_state_type;

endpackage

// ----- design/kth_smallest_distance_tracker.sv -----
// Streaming k-th smallest Manhattan distance, kept in a max-heap with a shared sift unit.
// Each item (x, y) gives |x|+|y| in 33 bits; the k smallest distances are kept in a max-heap
// in a RAM whose top is mirrored in a register, and one result per item reports the k-th
// smallest distance (zero and not valid until k items have been seen). Items are handled one
// at a time: accept, distance and decision states, then a sift with one RAM read state and
// one compare/write state per heap level crossed, at most floor(log2(k)) levels, then the
// new distance is placed (at the root or at a node with no children in the heap, or where a
// compare stops the sift), and then the result register is loaded. An item that does not beat
// the heap top once the heap is full skips the sift. A result that waits on rsp_ready holds
// the block until the output register is free. Writing k_rank empties the heap.
module kth_smallest_distance_tracker
   import ksdt_pkg::*;
#(
   parameter int MAX_K = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [COORD_W-1:0]    req_x_coord,
   input  logic signed [COORD_W-1:0]    req_y_coord,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [DIST_W-1:0]            rsp_kth_distance,
   output logic                         rsp_result_valid,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [CSR_DATA_W-1:0]        csr_pwdata,
   output logic [CSR_DATA_W-1:0]        csr_prdata,
   output logic                         csr_pready
);

   localparam int IDX_W = (MAX_K > 1) ? $clog2(MAX_K) : 1;
   localparam int CNT_W = $clog2(MAX_K + 1);
   localparam int CMP_W = (CNT_W > KRANK_W) ? CNT_W : KRANK_W;
   localparam int CHD_W = IDX_W + 2;

   ksdt_state_type state_ff, state_in;

   logic [COORD_W-1:0] abs_x_ff, abs_y_ff;
   logic [COORD_W-1:0] abs_x_in, abs_y_in;
   logic [DIST_W-1:0]  dist_ff, dist_in;
   logic [IDX_W-1:0]   pos_ff, pos_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [KRANK_W-1:0] k_ff;
   logic [DIST_W-1:0]  top_ff;

   logic               rsp_valid_ff;
   logic [DIST_W-1:0]  rsp_kth_ff;
   logic               rsp_res_valid_ff;
   logic               rsp_load;

   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [DIST_W-1:0]  wr_data;
   logic [IDX_W-1:0]   rd_addr_a, rd_addr_b;
   logic [DIST_W-1:0]  rd_data_a, rd_data_b;

   logic [CMP_W-1:0]   k_ext;
   logic [CNT_W-1:0]   k_eff;
   logic [IDX_W-1:0]   parent;
   logic [CHD_W-1:0]   left_w, right_w, k_chd;
   logic               csr_wr;
   logic               res_valid_now;

   // clamp the rank to 1..MAX_K
   always_comb begin
      k_ext = CMP_W'(k_ff);
      if (k_ext == '0) begin
         k_eff = CNT_W'(1);
      end else if (k_ext > CMP_W'(MAX_K)) begin
         k_eff = CNT_W'(MAX_K);
      end else begin
         k_eff = k_ext[CNT_W-1:0];
      end
   end

   assign parent  = IDX_W'((pos_ff - IDX_W'(1)) >> 1);
   assign left_w  = (CHD_W'(pos_ff) << 1) + CHD_W'(1);
   assign right_w = (CHD_W'(pos_ff) << 1) + CHD_W'(2);
   assign k_chd   = CHD_W'(k_eff);

   assign csr_wr  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign res_valid_now = (cnt_ff >= k_eff);

   ksdt_heap_ram #(
      .DEPTH  (MAX_K),
      .ADDR_W (IDX_W)
   ) u_heap_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      abs_x_in  = abs_x_ff;
      abs_y_in  = abs_y_ff;
      dist_in   = dist_ff;
      pos_in    = pos_ff;
      cnt_in    = cnt_ff;
      wr_en     = 1'b0;
      wr_addr   = pos_ff;
      wr_data   = dist_ff;
      rd_addr_a = parent;
      rd_addr_b = parent;
      rsp_load  = 1'b0;
      req_ready = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            abs_x_in  = req_x_coord[COORD_W-1] ? (~req_x_coord + COORD_W'(1)) : req_x_coord;
            abs_y_in  = req_y_coord[COORD_W-1] ? (~req_y_coord + COORD_W'(1)) : req_y_coord;
            if (req_valid) begin
               state_in = ST_DIST;
            end
         end
         ST_DIST: begin
            dist_in  = {1'b0, abs_x_ff} + {1'b0, abs_y_ff};
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (cnt_ff < k_eff) begin
               pos_in   = cnt_ff[IDX_W-1:0];
               cnt_in   = cnt_ff + CNT_W'(1);
               state_in = ST_UP_RD;
            end else if (dist_ff < top_ff) begin
               pos_in   = '0;
               state_in = ST_DN_RD;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_UP_RD: begin
            if (pos_ff == '0) begin
               wr_en    = 1'b1;
               state_in = ST_RESP;
            end else begin
               rd_addr_a = parent;
               state_in  = ST_UP_CMP;
            end
         end
         ST_UP_CMP: begin
            wr_en = 1'b1;
            if (rd_data_a < dist_ff) begin
               // pull the parent down into the hole
               wr_data  = rd_data_a;
               pos_in   = parent;
               state_in = ST_UP_RD;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_DN_RD: begin
            if (left_w >= k_chd) begin
               wr_en    = 1'b1;
               state_in = ST_RESP;
            end else begin
               rd_addr_a = left_w[IDX_W-1:0];
               rd_addr_b = right_w[IDX_W-1:0];
               state_in  = ST_DN_CMP;
            end
         end
         ST_DN_CMP: begin
            wr_en = 1'b1;
            if (rd_data_a > dist_ff) begin
               if (right_w < k_chd && rd_data_b > rd_data_a) begin
                  wr_data = rd_data_b;
                  pos_in  = right_w[IDX_W-1:0];
               end else begin
                  wr_data = rd_data_a;
                  pos_in  = left_w[IDX_W-1:0];
               end
               state_in = ST_DN_RD;
            end else if (right_w < k_chd && rd_data_b > dist_ff) begin
               wr_data  = rd_data_b;
               pos_in   = right_w[IDX_W-1:0];
               state_in = ST_DN_RD;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_wr && csr_paddr[CSR_ADDR_W-1] == REG_K_RANK) begin
         cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      abs_x_ff <= abs_x_in;
      abs_y_ff <= abs_y_in;
      dist_ff  <= dist_in;
      pos_ff   <= pos_in;
      if (wr_en && wr_addr == '0) begin
         top_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         k_ff   <= KRANK_W'(1);
      end else begin
         cnt_ff <= cnt_in;
         if (csr_wr && csr_paddr[CSR_ADDR_W-1] == REG_K_RANK) begin
            k_ff <= csr_pwdata[KRANK_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_res_valid_ff <= res_valid_now;
         rsp_kth_ff       <= res_valid_now ? top_ff : '0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kth_distance = rsp_kth_ff;
   assign rsp_result_valid = rsp_res_valid_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1] == REG_K_RANK) ?
                       CSR_DATA_W'(k_ff) : '0;

   a_cnt_bounded: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= k_eff)
      else $error("heap fill count exceeds rank");

   a_top_mirror: assert property (@(posedge clock) disable iff (reset)
      wr_en && wr_addr == '0 |=> top_ff == $past(wr_data))
      else $error("top register out of step with heap root");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_res_valid_ff |-> rsp_kth_ff == '0)
      else $error("not-valid result carries a distance");

   a_pos_in_heap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DN_RD || state_ff == ST_DN_CMP || state_ff == ST_UP_CMP)
      |-> CNT_W'(pos_ff) < k_eff)
      else $error("sift position outside heap");

endmodule

// ----- design/ksdt_heap_ram.sv -----
// Heap storage: one write port, two registered read ports.
module ksdt_heap_ram
   import ksdt_pkg::*;
#(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DIST_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr_a,
   input  logic [ADDR_W-1:0] rd_addr_b,
   output logic [DIST_W-1:0] rd_data_a,
   output logic [DIST_W-1:0] rd_data_b
);

   logic [DIST_W-1:0] mem [DEPTH];
   logic [DIST_W-1:0] rd_data_a_ff;
   logic [DIST_W-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_a_ff <= mem[rd_addr_a];
      rd_data_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// ----- tb/tb_kth_smallest_distance_tracker.sv -----
// Self-checking testbench for the k-th smallest distance tracker.
module tb_kth_smallest_distance_tracker;
   import ksdt_pkg::*;

   localparam int MAX_K      = 1024;
   localparam int DRAIN      = 40;     // a little over the longest sift of one item
   localparam int STALL_MAX  = 3000;   // cycles with no handshake of any kind
   localparam logic [CSR_ADDR_W-1:0] RANK_ADDR  = {REG_K_RANK, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR = {~REG_K_RANK, 2'b00};

   typedef struct packed {
      logic [DIST_W-1:0] kth_dist;
      logic              ok;
   } kth_item_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic signed [COORD_W-1:0] req_x_coord;
   logic signed [COORD_W-1:0] req_y_coord;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [DIST_W-1:0]         rsp_kth_distance;
   logic                      rsp_result_valid;
   logic                      csr_psel;
   logic                      csr_penable;
   logic                      csr_pwrite;
   logic [CSR_ADDR_W-1:0]     csr_paddr;
   logic [CSR_DATA_W-1:0]     csr_pwdata;
   logic [CSR_DATA_W-1:0]     csr_prdata;
   logic                      csr_pready;

   // predicted block state
   logic [DIST_W-1:0]  near_heap [MAX_K];
   int                 held;
   logic [KRANK_W-1:0] rank;

   kth_item_type kth_q[$];
   int   fails;
   int   points_sent;
   int   results_seen;
   int   valid_seen;
   int   rank_writes;
   bit   steady;

   kth_smallest_distance_tracker #(.MAX_K(MAX_K)) uut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [DIST_W-1:0] magnitude(input logic [COORD_W-1:0] v);
      return v[COORD_W-1] ? ({1'b0, ~v} + 1'b1) : {1'b0, v};
   endfunction

   // Advance the predicted heap by one point and return the expected result.
   function automatic kth_item_type track_point(input logic [COORD_W-1:0] x, y);
      int                k, pos, par, big, l, r;
      logic [DIST_W-1:0] d, t;
      kth_item_type      res;
      k   = (rank == 0) ? 1 : ((rank > MAX_K) ? MAX_K : int'(rank));
      d   = magnitude(x) + magnitude(y);
      res = '0;
      if (held < k) begin
         near_heap[held] = d;
         pos = held;
         while (pos > 0) begin
            par = (pos - 1) / 2;
            if (near_heap[par] < near_heap[pos]) begin
               t = near_heap[par];
               near_heap[par] = near_heap[pos];
               near_heap[pos] = t;
               pos = par;
            end else begin
               break;
            end
         end
         held++;
         if (held >= k) res = '{kth_dist: near_heap[0], ok: 1'b1};
      end else begin
         if (d < near_heap[0]) begin
            near_heap[0] = d;
            pos = 0;
            forever begin
               big = pos;
               l   = 2 * pos + 1;
               r   = l + 1;
               if (l < k && near_heap[l] > near_heap[big]) big = l;
               if (r < k && near_heap[r] > near_heap[big]) big = r;
               if (big == pos) break;
               t = near_heap[big];
               near_heap[big] = near_heap[pos];
               near_heap[pos] = t;
               pos = big;
            end
         end
         res = '{kth_dist: near_heap[0], ok: 1'b1};
      end
      return res;
   endfunction

   // Mostly small coordinates so that ties and replacements of the top are common.
   function automatic logic [COORD_W-1:0] random_coord();
      int sel;
      sel = $urandom_range(0, 19);
      if (sel < 10) return COORD_W'(int'($urandom_range(0, 100)) - 50);
      if (sel < 13) return COORD_W'(int'($urandom_range(0, 200000)) - 100000);
      if (sel < 18) return $urandom();
      case ($urandom_range(0, 4))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'hFFFF_FFFF;
         3: return 32'h0000_0001;
         default: return 32'h0000_0000;
      endcase
   endfunction

   // Leaves valid high after acceptance unless an idle burst follows.
   task automatic send_point(input logic [COORD_W-1:0] x, y);
      int gap;
      req_valid   <= 1'b1;
      req_x_coord <= x;
      req_y_coord <= y;
      do @(posedge clock); while (!req_ready);
      kth_q = {kth_q, track_point(x, y)};
      points_sent++;
      gap = (!steady && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (kth_q.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr[2] == REG_K_RANK) begin
         rank = data[KRANK_W-1:0];
         held = 0;
         rank_writes++;
      end
   endtask

   task automatic check_rank_readback();
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= RANK_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== CSR_DATA_W'(rank)) begin
         $error("k_rank: expected %0d, got %0d", rank, csr_prdata);
         fails++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_rank(input logic [CSR_DATA_W-1:0] data);
      csr_write(RANK_ADDR, data);
      check_rank_readback();
   endtask

   task automatic stream(input int k, input int n);
      set_rank(k);
      repeat (n) send_point(random_coord(), random_coord());
      settle();
   endtask

   // Rank 1 from reset: the result is the running minimum, starting at the largest distance.
   task automatic test_running_minimum();
      send_point(32'h8000_0000, 32'h8000_0000);
      send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_point(32'h7FFF_FFFF, 32'h8000_0000);
      send_point(32'hFFFF_FFFF, 32'h0000_0001);
      send_point(32'h0000_0001, 32'hFFFF_FFFF);
      send_point(32'h0000_0000, 32'h0000_0000);
      settle();
   endtask

   task automatic test_rank_register();
      // rank 0 behaves as rank 1
      set_rank(0);
      send_point(5, -5);
      send_point(-3, 0);
      settle();
      // a write outside the register map must neither empty the heap nor change the rank
      csr_write(SPARE_ADDR, 7);
      check_rank_readback();
      send_point(4, 4);
      settle();
      // upper data bits set; rank 3 covers not valid, the k-th point, ties and replacement
      set_rank(32'hFFFF_F803);
      send_point(10, 0);
      send_point(-20, 0);
      send_point(0, 30);
      send_point(25, 0);
      send_point(0, 25);
      send_point(100, 0);
      send_point(-1, -1);
      settle();
      // ranks above the heap size clamp to it
      set_rank(2047);
      repeat (3) send_point(random_coord(), random_coord());
      settle();
      set_rank(MAX_K);
      repeat (2) send_point(random_coord(), random_coord());
      settle();
   endtask

   task automatic test_random_ranks();
      stream(2, 50);
      stream(5, 50);
      stream(100, 130);
      stream($urandom_range(1, 20), 50);
      stream(13, 50);
   endtask

   task automatic test_steady_stream();
      steady = 1'b1;
      stream($urandom_range(3, 40), 80);
   endtask

   // Result side: random stall bursts, none once the run is steady.
   int stall_left = 0;
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= (stall_left == 0);
      end else if (!steady && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(1, 6);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      kth_item_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (kth_q.size() == 0) begin
            $error("unexpected result: kth_distance %0d, result_valid %0b",
                   rsp_kth_distance, rsp_result_valid);
            fails++;
         end else begin
            want = kth_q.pop_front();
            results_seen++;
            if (want.ok) valid_seen++;
            if (rsp_kth_distance !== want.kth_dist) begin
               $error("kth_distance: expected %0d, got %0d", want.kth_dist, rsp_kth_distance);
               fails++;
            end
            if (rsp_result_valid !== want.ok) begin
               $error("result_valid: expected %0b, got %0b", want.ok, rsp_result_valid);
               fails++;
            end
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < STALL_MAX) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_psel && csr_penable))
            quiet = 0;
         else
            quiet++;
      end
      $display("timeout: no handshake for %0d cycles, %0d results outstanding",
               STALL_MAX, kth_q.size());
      $display("simulation failed");
      $finish;
   end

   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_x_coord <= '0;
      req_y_coord <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      steady       = 1'b0;
      fails        = 0;
      points_sent  = 0;
      results_seen = 0;
      valid_seen   = 0;
      rank_writes  = 0;
      held         = 0;
      rank         = 1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_running_minimum();
      test_rank_register();
      test_random_ranks();
      test_steady_stream();

      $display("%0d points streamed through %0d rank writes (rank 0 up to 2047, plus a write",
               points_sent, rank_writes);
      $display("outside the map); %0d results checked, %0d of them valid.",
               results_seen, valid_seen);
      if (fails == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
